@@ hw/rtl/fresnel_reflectance_unit_top_macros.svh @@
// ----------------------------------------------------------------------------
// Fresnel reflectance unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i and muted in reset.
// ----------------------------------------------------------------------------
`ifndef FRESNEL_REFLECTANCE_UNIT_TOP_MACROS_SVH
`define FRESNEL_REFLECTANCE_UNIT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/fru_pkg.sv @@
// ----------------------------------------------------------------------------
// Fresnel reflectance unit package
// Field widths, fixed-point constants, the arctangent table and the stage
// record that travels down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fru_pkg;

  localparam int unsigned IDX_W   = 14;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned REFL_W  = 17;
  localparam int unsigned MAX_STEPS = 24;

  localparam logic [13:0] MIN_INDEX   = 14'd4096;
  localparam logic [15:0] HALF_PI_Q15 = 16'd51472;
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [31:0] ONE30       = 32'h4000_0000;
  localparam logic [33:0] GAIN_INV    = 34'd652032874;

  // atan(2^-i) in Q.30.
  localparam logic [31:0] ATAN_TAB [0:MAX_STEPS-1] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  // Working record of one word; each phase uses the fields it needs.
  typedef struct packed {
    logic               tir;
    logic [13:0]        n1;
    logic [13:0]        n2;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [30:0]        ci;
    logic [63:0]        acc;
    logic [33:0]        rem;
    logic [31:0]        quo;
    logic [31:0]        st;
    logic [29:0]        a;
    logic [29:0]        b;
    logic [29:0]        c;
    logic [29:0]        d;
    logic [30:0]        num0;
    logic [30:0]        den0;
    logic [30:0]        num1;
    logic [30:0]        den1;
    logic [31:0]        rem1;
    logic [30:0]        quo1;
    logic [15:0]        ta;
    logic [16:0]        rs;
    logic [16:0]        rp;
  } fru_work_t;

  // Result of the datapath handed to the output stage.
  typedef struct packed {
    logic        tir;
    logic [15:0] ta;
    logic [16:0] rs;
    logic [16:0] rp;
  } fru_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/fru_ifs.sv @@
// ----------------------------------------------------------------------------
// Fresnel reflectance unit channels
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fru_in_if import fru_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index_incident;
  logic [IDX_W-1:0] index_transmit;
  logic [ANG_W-1:0] incidence_angle;

  modport source (output valid, index_incident, index_transmit, incidence_angle,
                  input ready);
  modport sink (input valid, index_incident, index_transmit, incidence_angle,
                output ready);
endinterface

interface fru_out_if import fru_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ANG_W-1:0]  transmit_angle;
  logic [REFL_W-1:0] refl_s;
  logic [REFL_W-1:0] refl_p;
  logic [REFL_W-1:0] refl_mean;
  logic [REFL_W-1:0] trans_s;
  logic [REFL_W-1:0] trans_p;
  logic              total_internal;

  modport source (output valid, transmit_angle, refl_s, refl_p, refl_mean, trans_s,
                  trans_p, total_internal, input ready);
  modport sink (input valid, transmit_angle, refl_s, refl_p, refl_mean, trans_s,
                trans_p, total_internal, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fru_datapath.sv @@
// ----------------------------------------------------------------------------
// Fresnel reflectance datapath
// Pipelined CORDIC rotation, Snell divider, square root, Fresnel products,
// CORDIC vectoring, ratio dividers and squaring; one stage per step.
// ----------------------------------------------------------------------------
`default_nettype none

module fru_datapath import fru_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              in_vld_i,
  input  wire logic [IDX_W-1:0]  n1_i,
  input  wire logic [IDX_W-1:0]  n2_i,
  input  wire logic [ANG_W-1:0]  ang_i,
  output logic                   res_vld_o,
  output fru_result_t            res_o
);

  localparam int unsigned NSTEP    = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int unsigned S_PROD1  = NSTEP + 1;
  localparam int unsigned D1_BASE  = NSTEP + 2;
  localparam int unsigned S_SQ     = NSTEP + 34;
  localparam int unsigned RT_BASE  = NSTEP + 35;
  localparam int unsigned S_PROD2  = NSTEP + 66;
  localparam int unsigned S_SUM    = NSTEP + 67;
  localparam int unsigned V_BASE   = NSTEP + 68;
  localparam int unsigned S_TA     = 2 * NSTEP + 68;
  localparam int unsigned Q_BASE   = 2 * NSTEP + 69;
  localparam int unsigned S_LAST   = 2 * NSTEP + 100;

  fru_work_t          work_q [0:S_LAST];
  logic [S_LAST:0]    vld_q;

  // Valid bits travel with the words and hold when the pipe is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[S_LAST-1:0], in_vld_i};
    end
  end

  // Input stage: clamp the indices and the angle, seed the rotation.
  fru_work_t in_d;
  always_comb begin
    in_d    = '0;
    in_d.n1 = (n1_i < MIN_INDEX) ? MIN_INDEX : n1_i;
    in_d.n2 = (n2_i < MIN_INDEX) ? MIN_INDEX : n2_i;
    in_d.x  = $signed(GAIN_INV);
    in_d.y  = '0;
    in_d.z  = $signed({3'b000, ((ang_i > HALF_PI_Q15) ? HALF_PI_Q15 : ang_i), 15'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q[0] <= in_d;
    end
  end

  // CORDIC rotation: sine and cosine of the incidence angle.
  for (genvar gi = 0; gi < NSTEP; gi++) begin : g_rot
    localparam logic signed [33:0] AT = $signed({2'b00, ATAN_TAB[gi]});
    fru_work_t          nxt;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    always_comb begin
      nxt = work_q[gi];
      dx  = $signed(work_q[gi].y) >>> gi;
      dy  = $signed(work_q[gi].x) >>> gi;
      if (!work_q[gi].z[33]) begin
        nxt.x = work_q[gi].x - dx;
        nxt.y = work_q[gi].y + dy;
        nxt.z = work_q[gi].z - AT;
      end else begin
        nxt.x = work_q[gi].x + dx;
        nxt.y = work_q[gi].y - dy;
        nxt.z = work_q[gi].z + AT;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[gi+1] <= nxt;
      end
    end
  end

  // Clamp sine and cosine to the unit range and form n1 * sin_i.
  fru_work_t   p1_d;
  logic [30:0] p1_si;
  logic [44:0] p1_prod;
  always_comb begin
    p1_d = work_q[NSTEP];
    if (work_q[NSTEP].x[33]) begin
      p1_d.ci = '0;
    end else if (work_q[NSTEP].x > $signed({2'b00, ONE30})) begin
      p1_d.ci = ONE30[30:0];
    end else begin
      p1_d.ci = work_q[NSTEP].x[30:0];
    end
    if (work_q[NSTEP].y[33]) begin
      p1_si = '0;
    end else if (work_q[NSTEP].y > $signed({2'b00, ONE30})) begin
      p1_si = ONE30[30:0];
    end else begin
      p1_si = work_q[NSTEP].y[30:0];
    end
    p1_prod   = {31'b0, work_q[NSTEP].n1} * {14'b0, p1_si};
    p1_d.acc  = {20'b0, p1_prod[43:0]};
    p1_d.rem  = {22'b0, p1_prod[43:32]};
    p1_d.quo  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q[S_PROD1] <= p1_d;
    end
  end

  // Snell divider: sin_t = n1 * sin_i / n2, one quotient bit per stage.
  for (genvar gj = 0; gj < 32; gj++) begin : g_snell
    localparam int unsigned K = D1_BASE + gj;
    fru_work_t   nxt;
    logic [14:0] trial;
    always_comb begin
      nxt   = work_q[K-1];
      trial = {work_q[K-1].rem[13:0], work_q[K-1].acc[31-gj]};
      if (trial >= {1'b0, work_q[K-1].n2}) begin
        nxt.rem        = {19'b0, trial - {1'b0, work_q[K-1].n2}};
        nxt.quo[31-gj] = 1'b1;
      end else begin
        nxt.rem = {19'b0, trial};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[K] <= nxt;
      end
    end
  end

  // Critical angle check and the radicand one minus sin_t squared.
  fru_work_t   sq_d;
  logic [61:0] sq_prod;
  always_comb begin
    sq_d     = work_q[S_SQ-1];
    sq_d.st  = work_q[S_SQ-1].quo;
    sq_d.tir = work_q[S_SQ-1].quo > ONE30;
    sq_prod  = {31'b0, work_q[S_SQ-1].quo[30:0]} * {31'b0, work_q[S_SQ-1].quo[30:0]};
    sq_d.acc = sq_d.tir ? '0 : ((64'd1 << 60) - {2'b00, sq_prod});
    sq_d.rem = '0;
    sq_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q[S_SQ] <= sq_d;
    end
  end

  // Digit-by-digit square root for cos_t, one root bit per stage.
  for (genvar gr = 0; gr < 31; gr++) begin : g_sqrt
    localparam int unsigned K = RT_BASE + gr;
    localparam int unsigned P = 30 - gr;
    fru_work_t   nxt;
    logic [33:0] remt;
    logic [33:0] trial;
    always_comb begin
      nxt   = work_q[K-1];
      remt  = {work_q[K-1].rem[31:0], work_q[K-1].acc[2*P+1 -: 2]};
      trial = {1'b0, work_q[K-1].quo[30:0], 2'b01};
      if (remt >= trial) begin
        nxt.rem = remt - trial;
        nxt.quo = {1'b0, work_q[K-1].quo[29:0], 1'b1};
      end else begin
        nxt.rem = remt;
        nxt.quo = {1'b0, work_q[K-1].quo[29:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[K] <= nxt;
      end
    end
  end

  // Fresnel products n * cos, and the seed of the vectoring CORDIC.
  fru_work_t   p2_d;
  logic [44:0] p2_a;
  logic [44:0] p2_b;
  logic [44:0] p2_c;
  logic [44:0] p2_d_prod;
  always_comb begin
    p2_d      = work_q[S_PROD2-1];
    p2_a      = {31'b0, p2_d.n1} * {14'b0, p2_d.ci};
    p2_b      = {31'b0, p2_d.n2} * {14'b0, p2_d.quo[30:0]};
    p2_c      = {31'b0, p2_d.n1} * {14'b0, p2_d.quo[30:0]};
    p2_d_prod = {31'b0, p2_d.n2} * {14'b0, p2_d.ci};
    p2_d.a    = p2_a[43:14];
    p2_d.b    = p2_b[43:14];
    p2_d.c    = p2_c[43:14];
    p2_d.d    = p2_d_prod[43:14];
    p2_d.x    = $signed({3'b000, work_q[S_PROD2-1].quo[30:0]});
    p2_d.y    = $signed({2'b00, work_q[S_PROD2-1].st});
    p2_d.z    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q[S_PROD2] <= p2_d;
    end
  end

  // Numerators and denominators of both ratios; a zero denominator is TIR.
  fru_work_t sum_d;
  always_comb begin
    sum_d      = work_q[S_SUM-1];
    sum_d.den0 = {1'b0, sum_d.a} + {1'b0, sum_d.b};
    sum_d.den1 = {1'b0, sum_d.c} + {1'b0, sum_d.d};
    sum_d.num0 = (sum_d.a >= sum_d.b) ? {1'b0, sum_d.a - sum_d.b} : {1'b0, sum_d.b - sum_d.a};
    sum_d.num1 = (sum_d.c >= sum_d.d) ? {1'b0, sum_d.c - sum_d.d} : {1'b0, sum_d.d - sum_d.c};
    sum_d.tir  = work_q[S_SUM-1].tir || (sum_d.den0 == '0) || (sum_d.den1 == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q[S_SUM] <= sum_d;
    end
  end

  // CORDIC vectoring: refraction angle from (cos_t, sin_t).
  for (genvar gv = 0; gv < NSTEP; gv++) begin : g_vec
    localparam int unsigned K = V_BASE + gv;
    localparam logic signed [33:0] AT = $signed({2'b00, ATAN_TAB[gv]});
    fru_work_t          nxt;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    always_comb begin
      nxt = work_q[K-1];
      dx  = $signed(work_q[K-1].y) >>> gv;
      dy  = $signed(work_q[K-1].x) >>> gv;
      if (!work_q[K-1].y[33]) begin
        nxt.x = work_q[K-1].x + dx;
        nxt.y = work_q[K-1].y - dy;
        nxt.z = work_q[K-1].z + AT;
      end else begin
        nxt.x = work_q[K-1].x - dx;
        nxt.y = work_q[K-1].y + dy;
        nxt.z = work_q[K-1].z - AT;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[K] <= nxt;
      end
    end
  end

  // Round the angle to Q1.15 and clamp it to pi/2.
  fru_work_t   ta_d;
  logic [33:0] ta_rnd;
  always_comb begin
    ta_d   = work_q[S_TA-1];
    ta_rnd = work_q[S_TA-1].z + 34'd16384;
    if (work_q[S_TA-1].z[33]) begin
      ta_d.ta = '0;
    end else if (ta_rnd[33:15] > {3'b000, HALF_PI_Q15}) begin
      ta_d.ta = HALF_PI_Q15;
    end else begin
      ta_d.ta = ta_rnd[30:15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q[S_TA] <= ta_d;
    end
  end

  // Ratio dividers |num| * 2^30 / den for s and p, one bit per stage each.
  for (genvar gq = 0; gq < 31; gq++) begin : g_ratio
    localparam int unsigned K = Q_BASE + gq;
    fru_work_t   nxt;
    logic [31:0] t0;
    logic [31:0] t1;
    always_comb begin
      nxt = work_q[K-1];
      if (gq == 0) begin
        t0 = {1'b0, work_q[K-1].num0};
        t1 = {1'b0, work_q[K-1].num1};
      end else begin
        t0 = {work_q[K-1].rem[30:0], 1'b0};
        t1 = {work_q[K-1].rem1[30:0], 1'b0};
      end
      if (t0 >= {1'b0, work_q[K-1].den0}) begin
        nxt.rem        = {2'b00, t0 - {1'b0, work_q[K-1].den0}};
        nxt.quo[30-gq] = 1'b1;
      end else begin
        nxt.rem        = {2'b00, t0};
        nxt.quo[30-gq] = 1'b0;
      end
      if (t1 >= {1'b0, work_q[K-1].den1}) begin
        nxt.rem1        = t1 - {1'b0, work_q[K-1].den1};
        nxt.quo1[30-gq] = 1'b1;
      end else begin
        nxt.rem1        = t1;
        nxt.quo1[30-gq] = 1'b0;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[K] <= nxt;
      end
    end
  end

  // Square the ratios and round to Q1.16.
  fru_work_t   fin_d;
  logic [61:0] fin_s;
  logic [61:0] fin_p;
  always_comb begin
    fin_d    = work_q[S_LAST-1];
    fin_s    = {31'b0, work_q[S_LAST-1].quo[30:0]} * {31'b0, work_q[S_LAST-1].quo[30:0]}
               + (62'd1 << 43);
    fin_p    = {31'b0, work_q[S_LAST-1].quo1} * {31'b0, work_q[S_LAST-1].quo1}
               + (62'd1 << 43);
    fin_d.rs = fin_s[60:44];
    fin_d.rp = fin_p[60:44];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q[S_LAST] <= fin_d;
    end
  end

  assign res_vld_o = vld_q[S_LAST];
  assign res_o.tir = work_q[S_LAST].tir;
  assign res_o.ta  = work_q[S_LAST].ta;
  assign res_o.rs  = work_q[S_LAST].rs;
  assign res_o.rp  = work_q[S_LAST].rp;

endmodule

`default_nettype wire

@@ hw/rtl/fresnel_reflectance_unit_top.sv @@
// ----------------------------------------------------------------------------
// Fresnel reflectance unit
// Refraction angle, s and p reflectances, their mean and the transmittances
// of a dielectric interface for one ray per word.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while the output is not stalled and returns one
// result word per input word, in order. The pipe holds two CORDIC chains of one stage
// per iteration, a 32-stage Snell divider, a 31-stage square root, two 31-stage ratio
// dividers running side by side, the input, product, radicand, sum, angle and squaring
// stages, and the output register. When a result word waits in the output register and
// the sink holds ready low, the whole pipe freezes; input ready is low only while the
// output register is full and not taken.
`default_nettype none

`include "fresnel_reflectance_unit_top_macros.svh"

module fresnel_reflectance_unit_top import fru_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fru_in_if.sink    in_i,
  fru_out_if.source out_o
);

  logic        adv;
  logic        res_vld;
  fru_result_t res;

  logic        out_vld_q;
  logic [15:0] ang_q;
  logic [16:0] refl_s_q;
  logic [16:0] refl_p_q;
  logic [16:0] refl_mean_q;
  logic [16:0] trans_s_q;
  logic [16:0] trans_p_q;
  logic        tir_q;

  logic [17:0] mean_sum;

  logic        tir_word_ok;
  logic        energy_ok;
  logic        out_stall;

  // The pipe advances whenever the output register is free or being taken.
  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  fru_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .in_vld_i  (in_i.valid && adv),
    .n1_i      (in_i.index_incident),
    .n2_i      (in_i.index_transmit),
    .ang_i     (in_i.incidence_angle),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  assign mean_sum = {1'b0, res.rs} + {1'b0, res.rp} + 18'd1;

  // Output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_vld;
    end
  end

  // Output word: derived quantities, with the total reflection override.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tir_q <= res.tir;
      if (res.tir) begin
        ang_q       <= HALF_PI_Q15;
        refl_s_q    <= ONE_Q16;
        refl_p_q    <= ONE_Q16;
        refl_mean_q <= ONE_Q16;
        trans_s_q   <= '0;
        trans_p_q   <= '0;
      end else begin
        ang_q       <= res.ta;
        refl_s_q    <= res.rs;
        refl_p_q    <= res.rp;
        refl_mean_q <= mean_sum[17:1];
        trans_s_q   <= ONE_Q16 - res.rs;
        trans_p_q   <= ONE_Q16 - res.rp;
      end
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.transmit_angle = ang_q;
  assign out_o.refl_s         = refl_s_q;
  assign out_o.refl_p         = refl_p_q;
  assign out_o.refl_mean      = refl_mean_q;
  assign out_o.trans_s        = trans_s_q;
  assign out_o.trans_p        = trans_p_q;
  assign out_o.total_internal = tir_q;

  // Conditions checked by the assertions below.
  assign tir_word_ok = (refl_s_q == ONE_Q16) && (trans_p_q == '0) &&
                       (ang_q == HALF_PI_Q15);
  assign energy_ok   = (({1'b0, refl_s_q} + {1'b0, trans_s_q}) == {1'b0, ONE_Q16}) &&
                       (({1'b0, refl_p_q} + {1'b0, trans_p_q}) == {1'b0, ONE_Q16});
  assign out_stall   = out_vld_q && !out_o.ready;

  // A total reflection word carries the fixed override values.
  `FRU_ASSERT_SAME(a_tir_word, out_vld_q && tir_q, tir_word_ok, "bad total reflection word")

  // Reflectance and transmittance of a normal word add up to one.
  `FRU_ASSERT_SAME(a_energy_sum, out_vld_q && !tir_q, energy_ok, "R plus T is not one")

  // While the output is stalled the output stays valid and the last pipe stage keeps its valid bit.
  `FRU_ASSERT_NEXT(a_stall_hold, out_stall, out_vld_q && $stable(res_vld), "moved in stall")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Fresnel reflectance unit testbench
// Feeds index pairs and incidence angles through the unit under several
// handshake pressure phases and checks every result word against a CORDIC
// based predictor of refraction angle and reflectances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import fru_pkg::*;

  localparam int STEPS = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [13:0] n1;
    logic [13:0] n2;
    logic [15:0] ang;
  } ray_t;

  typedef struct packed {
    logic [15:0] ta;
    logic [16:0] rs;
    logic [16:0] rp;
    logic [16:0] rm;
    logic [16:0] ts;
    logic [16:0] tp;
    logic        tir;
  } optics_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fru_in_if  in_ch ();
  fru_out_if out_ch ();

  fresnel_reflectance_unit_top #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ray_t    pending_rays[$];
  optics_t expected_optics[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      mismatches = 0;
  int      results_seen = 0;
  int      tir_seen = 0;
  int      idle_cycles = 0;

  // Floor shift of a signed value.
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (num << 30) / den;
    if (q > 64'd1073741824) q = 64'd1073741824;
    return (q * q + (64'd1 << 43)) >> 44;
  endfunction

  // Snell refraction followed by the Fresnel reflectances.
  function automatic optics_t fresnel_predict(ray_t r);
    optics_t o;
    longint unsigned n1, n2, ang, a, b, c, d, ta, rs, rp, one30;
    longint x, y, z, dx, dy, ci, si, st, ct;
    one30 = 64'd1 << 30;
    n1 = (r.n1 < MIN_INDEX) ? MIN_INDEX : r.n1;
    n2 = (r.n2 < MIN_INDEX) ? MIN_INDEX : r.n2;
    ang = (r.ang > HALF_PI_Q15) ? HALF_PI_Q15 : r.ang;
    x = GAIN_INV; y = 0; z = longint'(ang << 15);
    for (int i = 0; i < STEPS && i < MAX_STEPS; i++) begin
      dx = asr(y, i); dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    ci = (x < 0) ? 0 : (x > longint'(one30)) ? longint'(one30) : x;
    si = (y < 0) ? 0 : (y > longint'(one30)) ? longint'(one30) : y;
    st = longint'((n1 * longint'(unsigned'(si))) / n2);
    o = '{ta: HALF_PI_Q15, rs: ONE_Q16, rp: ONE_Q16, rm: ONE_Q16, ts: 0, tp: 0, tir: 1'b1};
    if (st <= longint'(one30)) begin
      ct = longint'(int_sqrt((64'd1 << 60) - longint'(unsigned'(st)) * st));
      a = (n1 * ci) >> 14;
      b = (n2 * ct) >> 14;
      c = (n1 * ct) >> 14;
      d = (n2 * ci) >> 14;
      if (a + b != 0 && c + d != 0) begin
        x = ct; y = st; z = 0;
        for (int i = 0; i < STEPS && i < MAX_STEPS; i++) begin
          dx = asr(y, i); dy = asr(x, i);
          if (y >= 0) begin
            x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
          end else begin
            x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
          end
        end
        ta = (z < 0) ? 0 : (longint'(unsigned'(z)) + (64'd1 << 14)) >> 15;
        if (ta > HALF_PI_Q15) ta = HALF_PI_Q15;
        rs = sq_ratio((a >= b) ? a - b : b - a, a + b);
        rp = sq_ratio((c >= d) ? c - d : d - c, c + d);
        o.ta = ta[15:0];
        o.rs = rs[16:0];
        o.rp = rp[16:0];
        o.rm = 17'((rs + rp + 1) >> 1);
        o.ts = 17'(65536 - rs);
        o.tp = 17'(65536 - rp);
        o.tir = 1'b0;
      end
    end
    return o;
  endfunction

  // Driver: presents the next pending word, holding it until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.index_incident <= '0;
      in_ch.index_transmit <= '0;
      in_ch.incidence_angle <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_optics.push_back(fresnel_predict(
          '{n1: in_ch.index_incident, n2: in_ch.index_transmit,
            ang: in_ch.incidence_angle}));
      if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        ray_t r;
        r = pending_rays.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.index_incident <= r.n1;
        in_ch.index_transmit <= r.n2;
        in_ch.incidence_angle <= r.ang;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each taken result word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        optics_t got, want;
        got = '{ta: out_ch.transmit_angle, rs: out_ch.refl_s, rp: out_ch.refl_p,
                rm: out_ch.refl_mean, ts: out_ch.trans_s, tp: out_ch.trans_p,
                tir: out_ch.total_internal};
        results_seen++;
        if (expected_optics.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word %p", got);
        end else begin
          want = expected_optics.pop_front();
          if (want.tir) tir_seen++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Result %0d: expected %p, got %p",
                                           results_seen, want, got);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else if (rst_ni && (pending_rays.size() > 0 || expected_optics.size() > 0 || in_ch.valid))
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired");
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic ray_t random_ray();
    ray_t r;
    case ($urandom_range(9))
      0: r.n1 = 14'($urandom_range(4095));
      1: r.n1 = 14'($urandom);
      default: r.n1 = 14'($urandom_range(16383, 4096));
    endcase
    case ($urandom_range(9))
      0: r.n2 = 14'($urandom_range(4095));
      1: r.n2 = 14'($urandom);
      default: r.n2 = 14'($urandom_range(16383, 4096));
    endcase
    case ($urandom_range(9))
      0: r.ang = 16'($urandom);
      1: r.ang = 16'($urandom_range(51472, 50000));
      default: r.ang = 16'($urandom_range(51472));
    endcase
    return r;
  endfunction

  task automatic drain();
    while (pending_rays.size() > 0 || in_ch.valid || expected_optics.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int pct_send[4] = '{0, 84, 0, 8};
    int pct_recv[4] = '{0, 0, 84, 8};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: index and angle extremes, normal incidence, critical angle,
    // indices below one, angles past a right angle.
    pending_rays.push_back('{14'd4096, 14'd4096, 16'd0});
    pending_rays.push_back('{14'd16383, 14'd16383, 16'd51472});
    pending_rays.push_back('{14'd4096, 14'd16383, 16'd0});
    pending_rays.push_back('{14'd16383, 14'd4096, 16'd0});
    pending_rays.push_back('{14'd16383, 14'd4096, 16'd51472});
    pending_rays.push_back('{14'd4096, 14'd16383, 16'd51472});
    pending_rays.push_back('{14'd6144, 14'd4096, 16'd27444});
    pending_rays.push_back('{14'd6144, 14'd4096, 16'd23000});
    pending_rays.push_back('{14'd6144, 14'd4096, 16'd24000});
    pending_rays.push_back('{14'd0, 14'd0, 16'd25000});
    pending_rays.push_back('{14'd4095, 14'd6000, 16'd10000});
    pending_rays.push_back('{14'd8000, 14'd1, 16'd10000});
    pending_rays.push_back('{14'd5000, 14'd7000, 16'hFFFF});
    pending_rays.push_back('{14'd5000, 14'd7000, 16'd51473});
    pending_rays.push_back('{14'h3FFF, 14'h2AAA, 16'h5555});
    pending_rays.push_back('{14'd6000, 14'd6000, 16'd40000});
    pending_rays.push_back('{14'd4096, 14'd6000, 16'd1});
    pending_rays.push_back('{14'd4096, 14'd6000, 16'd51000});
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int k = 0; k < 300; k++) pending_rays.push_back(random_ray());
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2 * STEPS + 150) @(posedge clk_i);
    $display("Checked %0d result words, %0d of them total internal reflection,",
             results_seen, tir_seen);
    $display("across free-running, sender-idle, receiver-stall and mixed phases.");
    if (mismatches == 0 && expected_optics.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
